// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL. NO_ASSERTIONS compiles them away.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)

`define ASSERT_ALWAYS(label, clk, rst, expr)

`endif

`endif

// ===== design/ept_pkg.sv =====
// ----------------------------------------------------------------------------
// ept_pkg
// Types, sizes and helpers shared by the page error tracker modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ept_pkg;

  localparam int PAGE_SLOTS = 64;
  localparam int PAGE_SHIFT = 12;
  localparam int ADDR_BITS  = 56;
  localparam int COUNT_BITS = 16;

  localparam int ADDR_W  = 64;
  localparam int TAG_W   = ADDR_W - PAGE_SHIFT;
  localparam int IDX_W   = $clog2(PAGE_SLOTS);
  localparam int CNT_W   = $clog2(PAGE_SLOTS + 1);
  localparam int OUT_W   = 16;
  localparam int MIN_W   = 8;
  localparam int CFG_IDX_W = 1;

  localparam int CQ_DEPTH = 2;
  localparam int CQ_PW    = $clog2(CQ_DEPTH);
  localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

  localparam logic [ADDR_W-1:0] ADDR_RESET_MASK = {ADDR_W{1'b1}} >> (ADDR_W - ADDR_BITS);
  localparam logic [MIN_W-1:0]  MIN_SAMPLES_RESET = MIN_W'(3);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [CNT_W-1:0] SLOTS_FULL = CNT_W'(PAGE_SLOTS);

  localparam logic [CFG_IDX_W-1:0] REG_ADDRESS_MASK = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SAMPLES  = CFG_IDX_W'(1);

  typedef struct packed {
    logic             restart;
    logic             counted;
    logic [TAG_W-1:0] page;
  } cmd_t;

  typedef struct packed {
    logic             counted;
    logic [OUT_W-1:0] sample_total;
    logic [OUT_W-1:0] unique_pages;
    logic [OUT_W-1:0] largest_group;
    logic             measurable;
    logic             clustered;
    logic             table_overflow;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HIT,
    ST_RESULT
  } state_t;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == COUNT_MAX) ? v : v + COUNT_BITS'(1);
  endfunction

  function automatic logic [OUT_W-1:0] clamp_out(input logic [COUNT_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'h0000_FFFF) ? {OUT_W{1'b1}} : w[OUT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/error_page_cluster_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// error_page_cluster_tracker_unit
// Running page histogram of fault addresses from error records.
// ----------------------------------------------------------------------------
// Each record is masked and classified in the front stage, which takes one
// record per cycle, while the queue has room, into a two-deep request queue.
// The back end then handles one request at a time: a counted record searches
// the 64-entry page table through its single registered read port, one entry
// per cycle. A new page takes the next free entry if the table has room, and
// a hit bumps that entry's count; a record that is not counted skips the scan.
// The summary waits in an output register, so the next record is searched
// while the last result is unread.
// No clearing pass runs after reset; a restart empties the table on dequeue.
// ----------------------------------------------------------------------------
`default_nettype none

module error_page_cluster_tracker_unit
  import ept_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ADDR_W-1:0]    cfg_data,
  input  wire logic                 push,
  output      logic                 full,
  input  wire logic                 restart,
  input  wire logic                 address_present,
  input  wire logic [ADDR_W-1:0]    raw_address,
  output      logic                 empty,
  input  wire logic                 pop,
  output      logic                 counted,
  output      logic [OUT_W-1:0]     sample_total,
  output      logic [OUT_W-1:0]     unique_pages,
  output      logic [OUT_W-1:0]     largest_group,
  output      logic                 measurable,
  output      logic                 clustered,
  output      logic                 table_overflow
);

  logic [ADDR_W-1:0] address_mask;
  logic [MIN_W-1:0]  min_samples;
  logic              q_full;
  logic              q_push;
  cmd_t              q_wdata;
  logic              q_valid;
  logic              q_pop;
  cmd_t              q_rdata;
  logic              out_valid;
  res_t              out_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      address_mask <= ADDR_RESET_MASK;
      min_samples  <= MIN_SAMPLES_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ADDRESS_MASK: address_mask <= cfg_data;
        REG_MIN_SAMPLES:  min_samples  <= cfg_data[MIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ept_front u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .restart         (restart),
    .address_present (address_present),
    .raw_address     (raw_address),
    .address_mask    (address_mask),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_data          (q_wdata)
  );

  ept_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_push),
    .wr_data  (q_wdata),
    .q_full   (q_full),
    .rd_valid (q_valid),
    .rd       (q_pop),
    .rd_data  (q_rdata)
  );

  ept_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_data      (q_rdata),
    .q_pop       (q_pop),
    .min_samples (min_samples),
    .out_valid   (out_valid),
    .pop         (pop),
    .out_q       (out_q)
  );

  assign empty          = !out_valid;
  assign counted        = out_q.counted;
  assign sample_total   = out_q.sample_total;
  assign unique_pages   = out_q.unique_pages;
  assign largest_group  = out_q.largest_group;
  assign measurable     = out_q.measurable;
  assign clustered      = out_q.clustered;
  assign table_overflow = out_q.table_overflow;

endmodule

`default_nettype wire

// ===== design/ept_front.sv =====
// ----------------------------------------------------------------------------
// ept_front
// Input stage: masks the fault address, classifies the record and holds the
// resulting request until the command queue takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ept_front
  import ept_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output      logic              full,
  input  wire logic              restart,
  input  wire logic              address_present,
  input  wire logic [ADDR_W-1:0] raw_address,
  input  wire logic [ADDR_W-1:0] address_mask,
  input  wire logic              q_full,
  output      logic              q_push,
  output      cmd_t              q_data
);

  logic              stg_valid;
  cmd_t              stg;
  cmd_t              cls;
  logic [ADDR_W-1:0] masked;
  logic              accept;

  always_comb begin
    masked      = raw_address & address_mask;
    cls.restart = restart;
    cls.counted = address_present && (masked != '0);
    cls.page    = TAG_W'(masked >> PAGE_SHIFT);
  end

  assign full   = stg_valid && q_full;
  assign accept = push && !full;
  assign q_push = stg_valid && !q_full;
  assign q_data = stg;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (accept) begin
      stg_valid <= 1'b1;
    end else if (q_push) begin
      stg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg <= cls;
    end
  end

endmodule

`default_nettype wire

// ===== design/ept_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// ept_cmd_queue
// Short request queue between the classifying front and the table back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ept_cmd_queue
  import ept_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr,
  input  wire cmd_t wr_data,
  output      logic q_full,
  output      logic rd_valid,
  input  wire logic rd,
  output      cmd_t rd_data
);

  cmd_t             slots [CQ_DEPTH];
  logic [CQ_PW-1:0] wr_ptr;
  logic [CQ_PW-1:0] rd_ptr;
  logic [CQ_CW-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign q_full   = (count == CQ_CW'(CQ_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rd_ptr];
  assign do_wr    = wr && !q_full;
  assign do_rd    = rd && rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + CQ_PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + CQ_PW'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + CQ_CW'(1);
        2'b01:   count <= count - CQ_CW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== design/ept_back.sv =====
// ----------------------------------------------------------------------------
// ept_back
// Table back end: scans the page table one entry per cycle, updates the hit
// counts and running totals, and holds the summary in an output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ept_back
  import ept_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_valid,
  input  wire cmd_t             q_data,
  output      logic             q_pop,
  input  wire logic [MIN_W-1:0] min_samples,
  output      logic             out_valid,
  input  wire logic             pop,
  output      res_t             out_q
);

  state_t                state;
  state_t                state_next;

  logic [TAG_W-1:0]      tags [PAGE_SLOTS];
  logic [COUNT_BITS-1:0] hits_mem [PAGE_SLOTS];
  logic [TAG_W-1:0]      tag_q;
  logic [COUNT_BITS-1:0] hits_q;

  logic [TAG_W-1:0]      page_q;
  logic                  counted_q;
  logic [CNT_W-1:0]      used;
  logic [COUNT_BITS-1:0] samples;
  logic [COUNT_BITS-1:0] distinct;
  logic [COUNT_BITS-1:0] largest;
  logic                  overflow;

  logic [CNT_W-1:0]      issue_ptr;
  logic                  rd_pend;
  logic [IDX_W-1:0]      pend_idx;

  logic                  match;
  logic                  scan_end;
  logic                  miss;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_idx;
  logic                  tag_we;
  logic                  hits_we;
  logic [IDX_W-1:0]      wr_idx;
  logic [COUNT_BITS-1:0] hits_wdata;
  logic [COUNT_BITS-1:0] hit_inc;
  logic                  out_load;
  logic [COUNT_BITS-1:0] samples_base;
  logic                  meas;
  res_t                  res;

  assign match    = rd_pend && (tag_q == page_q);
  assign scan_end = (issue_ptr == used);
  assign rd_idx   = issue_ptr[IDX_W-1:0];
  assign hit_inc  = sat_inc(hits_q);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          state_next = q_data.counted ? ST_SCAN : ST_RESULT;
        end
      end
      ST_SCAN: begin
        if (match) begin
          state_next = ST_HIT;
        end else if (scan_end) begin
          state_next = ST_RESULT;
        end
      end
      ST_HIT:    state_next = ST_RESULT;
      ST_RESULT: begin
        if (!out_valid || pop) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop      = 1'b0;
    rd_en      = 1'b0;
    miss       = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE:   q_pop = q_valid;
      ST_SCAN: begin
        rd_en = !match && !scan_end;
        miss  = !match && scan_end;
      end
      ST_RESULT: out_load = !out_valid || pop;
      default: begin
      end
    endcase
    tag_we     = miss && (used != SLOTS_FULL);
    hits_we    = (state == ST_HIT) || tag_we;
    wr_idx     = (state == ST_HIT) ? pend_idx : used[IDX_W-1:0];
    hits_wdata = (state == ST_HIT) ? hit_inc : COUNT_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tags[wr_idx] <= page_q;
    end
    if (hits_we) begin
      hits_mem[wr_idx] <= hits_wdata;
    end
    if (rd_en) begin
      tag_q  <= tags[rd_idx];
      hits_q <= hits_mem[rd_idx];
    end
  end

  assign samples_base = q_data.restart ? '0 : samples;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      used      <= '0;
      samples   <= '0;
      distinct  <= '0;
      largest   <= '0;
      overflow  <= 1'b0;
      rd_pend   <= 1'b0;
      issue_ptr <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (q_pop) begin
        issue_ptr <= '0;
        rd_pend   <= 1'b0;
        samples   <= q_data.counted ? sat_inc(samples_base) : samples_base;
        if (q_data.restart) begin
          used     <= '0;
          distinct <= '0;
          largest  <= '0;
          overflow <= 1'b0;
        end
      end
      if (rd_en) begin
        issue_ptr <= issue_ptr + CNT_W'(1);
        rd_pend   <= 1'b1;
      end
      if ((state == ST_HIT) && (hit_inc > largest)) begin
        largest <= hit_inc;
      end
      if (miss) begin
        distinct <= sat_inc(distinct);
        if (largest == '0) begin
          largest <= COUNT_BITS'(1);
        end
        if (used != SLOTS_FULL) begin
          used <= used + CNT_W'(1);
        end else begin
          overflow <= 1'b1;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      page_q    <= q_data.page;
      counted_q <= q_data.counted;
    end
    if (rd_en) begin
      pend_idx <= rd_idx;
    end
    if (out_load) begin
      out_q <= res;
    end
  end

  always_comb begin
    meas               = (32'(samples) >= 32'(min_samples));
    res.counted        = counted_q;
    res.sample_total   = clamp_out(samples);
    res.unique_pages   = meas ? clamp_out(distinct) : '0;
    res.largest_group  = meas ? clamp_out(largest) : '0;
    res.measurable     = meas;
    res.clustered      = meas && ((33'(distinct) << 1) <= 33'(samples));
    res.table_overflow = overflow;
  end

  `ASSERT_ALWAYS(a_used_bounded, clk, rst, used <= SLOTS_FULL)
  `ASSERT_IMPLIES(a_overflow_full, clk, rst, overflow, used == SLOTS_FULL)
  `ASSERT_ALWAYS(a_distinct_le_samples, clk, rst, distinct <= samples)
  `ASSERT_IMPLIES(a_scan_in_range, clk, rst, state == ST_SCAN, issue_ptr <= used)

endmodule

`default_nettype wire

// ===== tb/error_page_cluster_tracker_unit_tb.sv =====
// ----------------------------------------------------------------------------
// error_page_cluster_tracker_unit_tb
// Self-checking bench for the page error tracker. A directed table covers
// reset state, skipped and masked-off records, hits and restarts; random
// phases then vary the mask and sample threshold and fill the page table past
// its end, and a final stretch without idling keeps hitting one page. Each
// summary is checked against a typed row's own value or an in-bench model.
// ----------------------------------------------------------------------------
module error_page_cluster_tracker_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ept_pkg::*;

  localparam int MAX_SILENT = 4000;
  localparam logic [ADDR_W-1:0] ALL_ONES = {ADDR_W{1'b1}};

  typedef struct packed {
    bit               restart;
    bit               present;
    logic [ADDR_W-1:0] addr;
    bit               typed;
    res_t             want;
  } stim_row_t;

  localparam int N_DIRECTED = 14;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{1'b0, 1'b0, 64'h0,                   1'b1, '{1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0}},
    '{1'b0, 1'b1, 64'h0,                   1'b1, '{1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0}},
    '{1'b0, 1'b1, 64'hFF00_0000_0000_0000, 1'b1, '{1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0}},
    '{1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{1'b1, 16'd1, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0}},
    '{1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{1'b1, 16'd2, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0}},
    '{1'b0, 1'b1, 64'h1,                   1'b1, '{1'b1, 16'd3, 16'd2, 16'd2, 1'b1, 1'b0, 1'b0}},
    '{1'b0, 1'b1, 64'hFFF,                 1'b1, '{1'b1, 16'd4, 16'd2, 16'd2, 1'b1, 1'b1, 1'b0}},
    '{1'b0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{1'b0, 16'd4, 16'd2, 16'd2, 1'b1, 1'b1, 1'b0}},
    '{1'b1, 1'b0, 64'h0,                   1'b1, '{1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0}},
    '{1'b1, 1'b1, 64'h1000,                1'b1, '{1'b1, 16'd1, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0}},
    '{1'b0, 1'b1, 64'h0100_0000_0000_0000, 1'b1, '{1'b0, 16'd1, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0}},
    '{1'b0, 1'b1, 64'h5A5A_5A5A_5A5A_5A5A, 1'b0, '0},
    '{1'b0, 1'b1, 64'hA5A5_A5A5_A5A5_A5A5, 1'b0, '0},
    '{1'b0, 1'b1, 64'h0000_0000_0000_1ABC, 1'b0, '0}
  };

  logic clk;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_ADDRESS_MASK;
  logic [ADDR_W-1:0] cfg_data = '0;
  logic push = 1'b0;
  logic full;
  logic restart = 1'b0;
  logic address_present = 1'b0;
  logic [ADDR_W-1:0] raw_address = '0;
  logic empty;
  logic pop = 1'b0;
  logic counted;
  logic [OUT_W-1:0] sample_total;
  logic [OUT_W-1:0] unique_pages;
  logic [OUT_W-1:0] largest_group;
  logic measurable;
  logic clustered;
  logic table_overflow;

  error_page_cluster_tracker_unit dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .full(full),
    .restart(restart), .address_present(address_present), .raw_address(raw_address),
    .empty(empty), .pop(pop),
    .counted(counted), .sample_total(sample_total), .unique_pages(unique_pages),
    .largest_group(largest_group), .measurable(measurable), .clustered(clustered),
    .table_overflow(table_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // tracker model state
  logic [ADDR_W-1:0]     cur_mask = ADDR_RESET_MASK;
  logic [MIN_W-1:0]      cur_min = MIN_SAMPLES_RESET;
  logic [TAG_W-1:0]      page_tag [PAGE_SLOTS];
  logic [COUNT_BITS-1:0] page_hit [PAGE_SLOTS];
  int unsigned           pages_held = 0;
  logic [COUNT_BITS-1:0] samples = '0;
  logic [COUNT_BITS-1:0] distinct = '0;
  logic [COUNT_BITS-1:0] largest = '0;
  bit                    overflowed = 1'b0;

  res_t summary_q [$];
  int   errors = 0;
  int   silent = 0;
  bit   calm = 1'b0;
  res_t got;
  res_t want;

  function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] v);
    return (v == {COUNT_BITS{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic res_t track_record(input bit rs, input bit ap,
                                        input logic [ADDR_W-1:0] addr);
    logic [ADDR_W-1:0] masked;
    logic [TAG_W-1:0]  page;
    bit                hit;
    bit                meas;
    res_t              r;
    if (rs) begin
      pages_held = 0;
      samples = '0;
      distinct = '0;
      largest = '0;
      overflowed = 1'b0;
    end
    r.counted = 1'b0;
    masked = addr & cur_mask;
    if (ap && masked != '0) begin
      r.counted = 1'b1;
      samples = bump(samples);
      page = TAG_W'(masked >> PAGE_SHIFT);
      hit = 1'b0;
      for (int i = 0; i < pages_held; i++) begin
        if (!hit && page_tag[IDX_W'(i)] == page) begin
          hit = 1'b1;
          page_hit[IDX_W'(i)] = bump(page_hit[IDX_W'(i)]);
          if (page_hit[IDX_W'(i)] > largest) largest = page_hit[IDX_W'(i)];
        end
      end
      if (!hit) begin
        distinct = bump(distinct);
        if (largest == '0) largest = COUNT_BITS'(1);
        if (pages_held < PAGE_SLOTS) begin
          page_tag[IDX_W'(pages_held)] = page;
          page_hit[IDX_W'(pages_held)] = COUNT_BITS'(1);
          pages_held++;
        end else begin
          overflowed = 1'b1;
        end
      end
    end
    meas = 32'(samples) >= 32'(cur_min);
    r.sample_total   = samples;
    r.unique_pages   = meas ? distinct : '0;
    r.largest_group  = meas ? largest : '0;
    r.measurable     = meas;
    r.clustered      = meas && (32'(distinct) * 2 <= 32'(samples));
    r.table_overflow = overflowed;
    return r;
  endfunction

  task automatic send_record(input bit rs, input bit ap, input logic [ADDR_W-1:0] addr,
                             input bit typed, input res_t typed_want);
    res_t r;
    if (!calm) begin
      while ($urandom_range(99) < 34) begin
        push <= 1'b0;
        @(posedge clk);
      end
    end
    push <= 1'b1;
    restart <= rs;
    address_present <= ap;
    raw_address <= addr;
    @(posedge clk);
    while (full) @(posedge clk);
    r = track_record(rs, ap, addr);
    summary_q.insert(summary_q.size(), typed ? typed_want : r);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (summary_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_ADDRESS_MASK) cur_mask = data;
    else cur_min = data[MIN_W-1:0];
    @(posedge clk);
  endtask

  // Each phase opens with a clearing request that counts nothing. Wide pools
  // are walked in order so the table fills and then overflows.
  task automatic run_phase(input logic [ADDR_W-1:0] mask, input logic [MIN_W-1:0] min_s,
                           input int pool_size, input int n_items, input int restart_pct);
    logic [TAG_W-1:0]  pool [96];
    logic [ADDR_W-1:0] a;
    int                kind;
    int                pick;
    bit                ap;
    drain();
    write_reg(REG_ADDRESS_MASK, mask);
    write_reg(REG_MIN_SAMPLES, {$urandom, $urandom} & ~64'hFF | 64'(min_s));
    for (int k = 0; k < pool_size; k++) pool[7'(k)] = TAG_W'({$urandom, $urandom});
    send_record(1'b1, 1'b0, {$urandom, $urandom}, 1'b0, '0);
    for (int n = 0; n < n_items; n++) begin
      kind = $urandom_range(99);
      ap = 1'b1;
      pick = (pool_size > 16) ? n % pool_size : $urandom_range(pool_size - 1);
      if (kind < 6) begin
        ap = 1'b0;
        a = {$urandom, $urandom};
      end else if (kind < 12) begin
        a = {$urandom, $urandom} & ~mask;
      end else if (kind < 18) begin
        a = {$urandom, $urandom};
      end else begin
        a = {pool[7'(pick)], 12'($urandom)};
      end
      send_record($urandom_range(99) < restart_pct, ap, a, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        got = '{counted, sample_total, unique_pages, largest_group,
                measurable, clustered, table_overflow};
        if (summary_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("summary with no request pending");
        end else begin
          want = summary_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display({"summary mismatch: want cnt=%0d n=%0d d=%0d g=%0d m=%0d c=%0d o=%0d",
                        " got cnt=%0d n=%0d d=%0d g=%0d m=%0d c=%0d o=%0d"},
                       want.counted, want.sample_total, want.unique_pages,
                       want.largest_group, want.measurable, want.clustered,
                       want.table_overflow, got.counted, got.sample_total,
                       got.unique_pages, got.largest_group, got.measurable,
                       got.clustered, got.table_overflow);
          end
        end
      end
      pop <= calm || $urandom_range(99) >= 34;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty)) begin
        silent <= 0;
      end else if (silent >= MAX_SILENT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        silent <= silent + 1;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++)
      send_record(DIRECTED[4'(i)].restart, DIRECTED[4'(i)].present, DIRECTED[4'(i)].addr,
                  DIRECTED[4'(i)].typed, DIRECTED[4'(i)].want);

    run_phase(ALL_ONES, 8'd0, 6, 60, 3);
    run_phase(64'h0, 8'd255, 6, 20, 5);
    run_phase(64'h0000_FFFF_FFFF_F000, 8'd1, 90, 100, 0);
    run_phase({$urandom, $urandom}, 8'($urandom_range(8)), 12, 60, 3);
    run_phase(ADDR_RESET_MASK, MIN_SAMPLES_RESET, 90, 100, 0);

    // one page hit over and over with a few stray addresses, no idling
    drain();
    write_reg(REG_ADDRESS_MASK, ALL_ONES);
    write_reg(REG_MIN_SAMPLES, 64'd40);
    calm = 1'b1;
    for (int i = 0; i < 60; i++)
      send_record(i == 0, 1'b1,
                  (i % 16 == 15) ? {$urandom, $urandom} | 64'h1
                                 : {52'h8_7E57_0000_0001, 12'($urandom)},
                  1'b0, '0);
    calm = 1'b0;

    push <= 1'b0;
    while (summary_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/ept_pkg.sv
design/ept_front.sv
design/ept_cmd_queue.sv
design/ept_back.sv
design/error_page_cluster_tracker_unit.sv
tb/error_page_cluster_tracker_unit_tb.sv
